@@ sv/v2d_pkg.sv @@
// Package for the two-dimensional vector arithmetic unit.
// Holds the operation codes, the fixed-point format constants and the pipeline depths.
package v2d_pkg;
    localparam int FRAC_BITS = 16;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_BITS = 32 + FRAC_BITS;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_SCALE = 3'd2,
        OP_LENGTH = 3'd3,
        OP_NORM = 3'd4
    } t_op;
endpackage

@@ sv/v2d_sqrt.sv @@
// Pipelined floor square root of a 64-bit unsigned value, one result bit per stage.
// Depends on v2d_pkg; every stage advances on i_en, so a stall holds all stages.
module v2d_sqrt import v2d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);
    logic [63:0] r_rem  [SQRT_STAGES];
    logic [31:0] r_root [SQRT_STAGES];

    // Stage k decides root bit 31-k by trying (2*root + 1) << shift against the remainder.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                logic [63:0] rem_in;
                logic [31:0] root_in;
                logic [65:0] trial;
                rem_in  = (k == 0) ? i_val : r_rem[k-1];
                root_in = (k == 0) ? 32'd0 : r_root[k-1];
                trial   = ({34'd0, root_in} << (32 - k)) | (66'd1 << (62 - 2*k));
                if ({2'b00, rem_in} >= trial) begin
                    r_rem[k]  <= rem_in - trial[63:0];
                    r_root[k] <= root_in | (32'd1 << (31 - k));
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];
endmodule

@@ sv/vector2d_arith_unit.sv @@
// Top level of the two-dimensional vector arithmetic unit.
// Depends on v2d_pkg and v2d_sqrt.
//
// The unit computes add, subtract, scale, length or normalize on signed fixed-point
// vectors with FRAC_BITS fractional bits. It accepts one transfer per cycle and
// returns exactly one result per transfer, in order. Every item travels through the
// same pipeline of 3 + SQRT_STAGES + DIV_BITS + 1 register stages (84 at Q16.16):
// one stage registers the operands, one stage forms the products, one stage sums the
// squares and finishes add, subtract and scale, the square root takes one result bit
// per stage, and the restoring divider for normalize takes one quotient bit per stage
// for both components side by side, followed by the output register. Add, subtract
// and scale results simply ride along with their valid bit. The whole pipeline
// advances whenever the output register is empty or is being taken, so a stall
// freezes every stage and nothing is lost or repeated.
module vector2d_arith_unit import v2d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_scale_factor,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic [31:0] o_magnitude,
    output logic        o_saturated
);
    localparam int NDEPTH = SQRT_STAGES + DIV_BITS;

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // Stage 0: operand register.
    logic        r_v0;
    logic [2:0]  r_kind0;
    logic signed [31:0] r_ax, r_ay, r_bx, r_by, r_sf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
        if (adv) begin
            r_kind0 <= i_kind;
            r_ax <= i_ax; r_ay <= i_ay; r_bx <= i_bx; r_by <= i_by;
            r_sf <= i_scale_factor;
        end
    end

    // Stage 1: products, sums and the simple results.
    function automatic logic [32:0] clamp33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) return {1'b1, 32'h7FFFFFFF};
        if (v < -33'sd2147483648) return {1'b1, 32'h80000000};
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] scale_fix(input logic signed [63:0] p);
        logic [63:0] m;
        logic signed [64:0] q;
        m = p[63] ? (~p + 64'd1) : p;
        m = m >> FRAC_BITS;
        q = p[63] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        if (q > 65'sd2147483647) return {1'b1, 32'h7FFFFFFF};
        if (q < -65'sd2147483648) return {1'b1, 32'h80000000};
        return {1'b0, q[31:0]};
    endfunction

    logic        r_v1;
    logic [2:0]  r_kind1;
    logic signed [31:0] r_ax1, r_ay1;
    logic signed [63:0] r_px, r_py;
    logic [63:0] r_sqx, r_sqy;
    logic [32:0] r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_v0;
        end
        if (adv) begin
            r_kind1 <= r_kind0;
            r_ax1 <= r_ax; r_ay1 <= r_ay;
            r_px  <= r_ax * r_sf;
            r_py  <= r_ay * r_sf;
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            if (r_kind0 == OP_SUB) begin
                r_sx <= clamp33(33'(r_ax) - 33'(r_bx));
                r_sy <= clamp33(33'(r_ay) - 33'(r_by));
            end else begin
                r_sx <= clamp33(33'(r_ax) + 33'(r_bx));
                r_sy <= clamp33(33'(r_ay) + 33'(r_by));
            end
        end
    end

    // Stage 2: sum of squares and the finished add, subtract or scale result.
    logic        r_v2;
    logic [2:0]  r_kind2;
    logic signed [31:0] r_ax2, r_ay2;
    logic [63:0] r_sum;
    logic [32:0] r_fx, r_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
        if (adv) begin
            r_kind2 <= r_kind1;
            r_ax2 <= r_ax1; r_ay2 <= r_ay1;
            r_sum <= r_sqx + r_sqy;
            unique case (r_kind1)
                OP_ADD, OP_SUB: begin
                    r_fx <= r_sx; r_fy <= r_sy;
                end
                OP_SCALE: begin
                    r_fx <= scale_fix(r_px); r_fy <= scale_fix(r_py);
                end
                default: begin
                    r_fx <= '0; r_fy <= '0;
                end
            endcase
        end
    end

    // Square root pipeline; sideband delay line alongside it.
    logic [31:0] sq_root;
    v2d_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r_sum),
        .o_root (sq_root)
    );

    logic [NDEPTH-1:0] r_vd;
    logic [2:0]  r_kd  [NDEPTH];
    logic [32:0] r_fxd [NDEPTH];
    logic [32:0] r_fyd [NDEPTH];
    logic        r_nx  [NDEPTH];
    logic        r_ny  [NDEPTH];
    logic [DIV_BITS-1:0] r_ax_m [SQRT_STAGES];
    logic [DIV_BITS-1:0] r_ay_m [SQRT_STAGES];
    logic [31:0] r_mag [DIV_BITS];

    // Divider state per stage: remainder, quotient, divisor.
    logic [32:0] r_rmx [DIV_BITS];
    logic [32:0] r_rmy [DIV_BITS];
    logic [DIV_BITS-1:0] r_qx [DIV_BITS];
    logic [DIV_BITS-1:0] r_qy [DIV_BITS];
    logic [31:0] r_dv [DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else if (adv) begin
            r_vd <= {r_vd[NDEPTH-2:0], r_v2};
        end
        if (adv) begin
            for (int k = 0; k < NDEPTH; k++) begin
                r_kd[k]  <= (k == 0) ? r_kind2 : r_kd[k-1];
                r_fxd[k] <= (k == 0) ? r_fx : r_fxd[k-1];
                r_fyd[k] <= (k == 0) ? r_fy : r_fyd[k-1];
                r_nx[k]  <= (k == 0) ? r_ax2[31] : r_nx[k-1];
                r_ny[k]  <= (k == 0) ? r_ay2[31] : r_ny[k-1];
            end
            for (int k = 0; k < SQRT_STAGES; k++) begin
                if (k == 0) begin
                    r_ax_m[k] <= DIV_BITS'(r_ax2[31] ? -33'(r_ax2) : 33'(r_ax2)) << FRAC_BITS;
                    r_ay_m[k] <= DIV_BITS'(r_ay2[31] ? -33'(r_ay2) : 33'(r_ay2)) << FRAC_BITS;
                end else begin
                    r_ax_m[k] <= r_ax_m[k-1];
                    r_ay_m[k] <= r_ay_m[k-1];
                end
            end
            // Restoring division, one quotient bit per stage, MSB first.
            for (int k = 0; k < DIV_BITS; k++) begin
                logic [32:0] rx_in, ry_in, tx, ty;
                logic [DIV_BITS-1:0] qx_in, qy_in;
                logic [31:0] d;
                d     = (k == 0) ? sq_root : r_dv[k-1];
                rx_in = (k == 0) ? 33'd0 : r_rmx[k-1];
                ry_in = (k == 0) ? 33'd0 : r_rmy[k-1];
                qx_in = (k == 0) ? r_ax_m[SQRT_STAGES-1] : r_qx[k-1];
                qy_in = (k == 0) ? r_ay_m[SQRT_STAGES-1] : r_qy[k-1];
                tx = {rx_in[31:0], qx_in[DIV_BITS-1]};
                ty = {ry_in[31:0], qy_in[DIV_BITS-1]};
                r_dv[k]  <= d;
                r_mag[k] <= (k == 0) ? sq_root : r_mag[k-1];
                if (tx >= {1'b0, d}) begin
                    r_rmx[k] <= tx - {1'b0, d};
                    r_qx[k]  <= {qx_in[DIV_BITS-2:0], 1'b1};
                end else begin
                    r_rmx[k] <= tx;
                    r_qx[k]  <= {qx_in[DIV_BITS-2:0], 1'b0};
                end
                if (ty >= {1'b0, d}) begin
                    r_rmy[k] <= ty - {1'b0, d};
                    r_qy[k]  <= {qy_in[DIV_BITS-2:0], 1'b1};
                end else begin
                    r_rmy[k] <= ty;
                    r_qy[k]  <= {qy_in[DIV_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Output register.
    logic [31:0] qx_fin, qy_fin, mag_fin;
    logic        zero_len;
    assign mag_fin  = r_mag[DIV_BITS-1];
    assign zero_len = (r_dv[DIV_BITS-1] == 32'd0);
    assign qx_fin   = r_qx[DIV_BITS-1][31:0];
    assign qy_fin   = r_qy[DIV_BITS-1][31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_vd[NDEPTH-1];
        end
        if (adv) begin
            unique case (r_kd[NDEPTH-1])
                OP_ADD, OP_SUB, OP_SCALE: begin
                    o_rx <= r_fxd[NDEPTH-1][31:0];
                    o_ry <= r_fyd[NDEPTH-1][31:0];
                    o_magnitude <= '0;
                    o_saturated <= r_fxd[NDEPTH-1][32] | r_fyd[NDEPTH-1][32];
                end
                OP_LENGTH: begin
                    o_rx <= '0;
                    o_ry <= '0;
                    o_magnitude <= mag_fin;
                    o_saturated <= 1'b0;
                end
                OP_NORM: begin
                    // A zero vector has no direction and normalizes to (0,0).
                    o_rx <= zero_len ? 32'd0 : (r_nx[NDEPTH-1] ? -qx_fin : qx_fin);
                    o_ry <= zero_len ? 32'd0 : (r_ny[NDEPTH-1] ? -qy_fin : qy_fin);
                    o_magnitude <= '0;
                    o_saturated <= 1'b0;
                end
                default: begin
                    o_rx <= '0;
                    o_ry <= '0;
                    o_magnitude <= '0;
                    o_saturated <= 1'b0;
                end
            endcase
        end
    end
endmodule
